// ===== hdl/msq_pkg.sv =====
// shared types and constants of the midi pattern step sequencer
`default_nettype none

package msq_pkg;

  // pattern and slot counts, tied to the widths of the index fields
  localparam int unsigned PATTERNS = 2;
  localparam int unsigned NOTES    = 5;

  localparam int unsigned FpbW   = 20;
  localparam int unsigned PosW   = 32;
  localparam int unsigned BeatsW = 7;
  localparam int unsigned PitchW = 7;
  localparam int unsigned SixW   = 10;
  localparam int unsigned FrameW = 16;

  // a count of sixteenths times frames per beat, before the divide by sixteen
  localparam int unsigned ProdW  = SixW + FpbW;
  localparam int unsigned FrmW   = ProdW - 4;
  localparam int unsigned LoopW  = BeatsW + FpbW;

  typedef enum logic [1:0] {
    CMD_TICK    = 2'd0,
    CMD_NOTE    = 2'd1,
    CMD_PATTERN = 2'd2
  } cmd_e;

  localparam logic CFG_FPB  = 1'b0;
  localparam logic CFG_PLAY = 1'b1;

  localparam logic [FpbW-1:0]   FPB_RESET  = 20'd24000;
  localparam logic [7:0]        STATUS_ON  = 8'h90;
  localparam logic [7:0]        STATUS_OFF = 8'h80;
  localparam logic [6:0]        VEL_ON     = 7'd100;
  localparam logic [6:0]        VEL_OFF    = 7'd0;
  localparam logic [PitchW-1:0] PITCH_MAX  = 7'd127;

  typedef struct packed {
    logic [1:0]        command;
    logic [FrameW-1:0] frame_offset;
    logic              pattern_index;
    logic [2:0]        note_index;
    logic [SixW-1:0]   start_sixteenths;
    logic [SixW-1:0]   length_sixteenths;
    logic [PitchW-1:0] pitch_offset;
    logic [BeatsW-1:0] length_beats;
    logic [PitchW-1:0] base_pitch;
    logic              active;
  } item_t;

  typedef struct packed {
    logic [FrameW-1:0] event_frame;
    logic [7:0]        status_byte;
    logic [6:0]        note_number;
    logic [6:0]        note_velocity;
    logic              source_pattern;
    logic [2:0]        source_slot;
    logic              last_event;
  } result_t;

  typedef struct packed {
    logic [SixW-1:0]   start_sixteenths;
    logic [SixW-1:0]   length_sixteenths;
    logic [PitchW-1:0] pitch;
  } slot_word_t;

  typedef struct packed {
    logic [PosW-1:0]   pos;
    logic [BeatsW-1:0] loop_beats;
    logic [PitchW-1:0] base;
    logic              on;
  } pat_fix_t;

  // decision of the note evaluation pipe for the slot in its last stage
  typedef struct packed {
    logic              vld;
    logic              note_on;
    logic              note_stop;
    logic [PitchW-1:0] pitch;
    logic              pipe_busy;
  } eval_t;

endpackage

`default_nettype wire

// ===== hdl/msq_ram.sv =====
// generic simple dual port ram with registered read
`default_nettype none

module msq_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16,
  localparam int unsigned AW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    waddr_i,
  input  wire logic [Width-1:0] wdata_i,
  input  wire logic [AW-1:0]    raddr_i,
  output logic      [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

`default_nettype wire

// ===== hdl/msq_note_eval.sv =====
// note evaluation pipe: frame scaling, note end, on and off decision
`default_nettype none

module msq_note_eval import msq_pkg::*; #(
  localparam int unsigned NW = (NOTES > 1) ? $clog2(NOTES) : 1
) (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            rd_vld_i,
  input  wire logic [NW-1:0]   rd_slot_i,
  input  wire slot_word_t      slot_word_i,
  input  wire logic [FpbW-1:0] fpb_i,
  input  wire logic [PitchW-1:0] base_i,
  input  wire logic [PosW-1:0] pos_i,
  input  wire logic [NOTES-1:0] snd_i,
  output eval_t                eval_o,
  output logic      [NW-1:0]   slot_o
);

  logic              v2_q, v3_q;
  logic [NW-1:0]     n2_q, n3_q;
  logic [ProdW-1:0]  ps_q, pl_q;
  logic [PitchW:0]   psum_q;
  logic [FrmW-1:0]   ns_q;
  logic [PosW-1:0]   ne_q, nem1_q;
  logic [PitchW-1:0] pitch_q;

  logic [ProdW-1:0]  ps_d, pl_d;
  logic [PosW-1:0]   ne_d;
  logic              snd, in_range;

  assign ps_d = ProdW'(slot_word_i.start_sixteenths) * ProdW'(fpb_i);
  assign pl_d = ProdW'(slot_word_i.length_sixteenths) * ProdW'(fpb_i);
  assign ne_d = PosW'(ps_q[ProdW-1:4]) + PosW'(pl_q[ProdW-1:4]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      v2_q <= rd_vld_i;
      v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    n2_q   <= rd_slot_i;
    ps_q   <= ps_d;
    pl_q   <= pl_d;
    psum_q <= {1'b0, base_i} + {1'b0, slot_word_i.pitch};
    n3_q   <= n2_q;
    ns_q   <= ps_q[ProdW-1:4];
    ne_q   <= ne_d;
    nem1_q <= ne_d - PosW'(1);
    pitch_q <= psum_q[PitchW] ? PITCH_MAX : psum_q[PitchW-1:0];
  end

  assign snd      = snd_i[n3_q];
  assign in_range = (pos_i >= PosW'(ns_q)) && (pos_i < ne_q);

  assign eval_o.vld       = v3_q;
  assign eval_o.note_on   = v3_q && !snd && in_range;
  assign eval_o.note_stop = v3_q && snd && (pos_i == nem1_q);
  assign eval_o.pitch     = pitch_q;
  assign eval_o.pipe_busy = v2_q || v3_q;
  assign slot_o           = n3_q;

endmodule

`default_nettype wire

// ===== hdl/midi_pattern_step_sequencer_unit.sv =====
// looping midi pattern step sequencer, top level
// writes take effect at the accept edge; busy stays low for them and for a tick while stopped
// a tick keeps busy high while each pattern is read; an active pattern has its slot memory
// walked one slot a cycle through a 3-stage pipe and is written back; a done state ends it
// words come one per strobe; the final one shows in the first cycle with busy low
// after reset a clearing pass over both memories keeps busy high
`default_nettype none

module midi_pattern_step_sequencer_unit import msq_pkg::*; (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            start,
  output logic                 busy,
  input  wire item_t           item_i,
  output logic                 result_valid_o,
  output result_t              result_o,
  input  wire logic            cfg_we_i,
  input  wire logic            cfg_addr_i,
  input  wire logic [FpbW-1:0] cfg_wdata_i
);

  localparam int unsigned SLOTS = PATTERNS * NOTES;
  localparam int unsigned SW    = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int unsigned PW    = (PATTERNS > 1) ? $clog2(PATTERNS) : 1;
  localparam int unsigned NW    = (NOTES > 1) ? $clog2(NOTES) : 1;
  localparam int unsigned NCW   = $clog2(NOTES + 1);
  localparam int unsigned FIXW  = $bits(pat_fix_t);
  localparam int unsigned PWW   = FIXW + NOTES;
  localparam int unsigned SLW   = $bits(slot_word_t);

  localparam logic [2:0] ST_CLEAR = 3'd0;
  localparam logic [2:0] ST_IDLE  = 3'd1;
  localparam logic [2:0] ST_PREAD = 3'd2;
  localparam logic [2:0] ST_PLOAD = 3'd3;
  localparam logic [2:0] ST_WALK  = 3'd4;
  localparam logic [2:0] ST_WBACK = 3'd5;
  localparam logic [2:0] ST_DONE  = 3'd6;

  logic [2:0]        state_q, state_d;
  logic [SW-1:0]     clr_q, clr_d;
  logic [PW-1:0]     pat_q, pat_d;
  logic [SW-1:0]     base_q, base_d;
  logic [NCW-1:0]    iss_q, iss_d;
  logic              v1_q, v1_d;
  logic [NW-1:0]     n1_q, n1_d;
  logic [FrameW-1:0] frame_q, frame_d;
  logic [FpbW-1:0]   fpb_q;
  logic              play_q;
  logic [PosW-1:0]   pos_q, pos_d;
  logic [LoopW-1:0]  loop_end_q, loop_end_d;
  logic [BeatsW-1:0] ploop_q, ploop_d;
  logic [PitchW-1:0] pbase_q, pbase_d;
  logic [NOTES-1:0]  snd_q, snd_d;
  logic              pend_q, pend_d;
  result_t           pend_res_q, pend_res_d;
  result_t           res_q, res_d;
  logic              res_vld_q, res_vld_d;

  logic              accept;
  logic              pat_we, slot_we;
  logic [PW-1:0]     pat_waddr;
  logic [PWW-1:0]    pat_wdata, pat_rdata;
  logic [SW-1:0]     slot_waddr, slot_raddr;
  logic [SLW-1:0]    slot_wdata, slot_rdata;
  pat_fix_t          pat_rd, pat_wr;
  slot_word_t        slot_wr;
  eval_t             eval;
  logic [NW-1:0]     eval_slot;
  logic [PosW-1:0]   pos_inc;
  logic              pat_last;
  logic              pat_ok, note_ok;
  result_t           new_res;

  assign busy   = (state_q != ST_IDLE);
  assign accept = start && !busy;
  assign pat_rd = pat_fix_t'(pat_rdata[PWW-1 -: FIXW]);
  assign pat_last = (pat_q == PW'(PATTERNS - 1));
  assign pat_ok  = (32'(item_i.pattern_index) < PATTERNS);
  assign note_ok = pat_ok && (32'(item_i.note_index) < NOTES);
  assign pos_inc = pos_q + PosW'(1);
  assign slot_raddr = base_q + SW'(iss_q);

  msq_ram #(.Width(PWW), .Depth(PATTERNS)) u_pat_ram (
    .clk_i   (clk_i),
    .we_i    (pat_we),
    .waddr_i (pat_waddr),
    .wdata_i (pat_wdata),
    .raddr_i (pat_q),
    .rdata_o (pat_rdata)
  );

  msq_ram #(.Width(SLW), .Depth(SLOTS)) u_slot_ram (
    .clk_i   (clk_i),
    .we_i    (slot_we),
    .waddr_i (slot_waddr),
    .wdata_i (slot_wdata),
    .raddr_i (slot_raddr),
    .rdata_o (slot_rdata)
  );

  msq_note_eval u_eval (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .rd_vld_i    (v1_q),
    .rd_slot_i   (n1_q),
    .slot_word_i (slot_word_t'(slot_rdata)),
    .fpb_i       (fpb_q),
    .base_i      (pbase_q),
    .pos_i       (pos_q),
    .snd_i       (snd_q),
    .eval_o      (eval),
    .slot_o      (eval_slot)
  );

  // memory write ports: clearing pass, write commands, pattern write-back
  always_comb begin
    pat_we     = 1'b0;
    pat_waddr  = pat_q;
    pat_wr     = '0;
    pat_wdata  = '0;
    slot_we    = 1'b0;
    slot_waddr = clr_q;
    slot_wr    = '0;
    slot_wdata = '0;
    priority if (state_q == ST_CLEAR) begin
      pat_we    = (32'(clr_q) < PATTERNS);
      pat_waddr = PW'(clr_q);
      slot_we   = 1'b1;
    end else if (state_q == ST_WBACK) begin
      pat_we         = 1'b1;
      pat_wr.pos     = (pos_inc == PosW'(loop_end_q)) ? '0 : pos_inc;
      pat_wr.loop_beats = ploop_q;
      pat_wr.base    = pbase_q;
      pat_wr.on      = 1'b1;
      pat_wdata      = {pat_wr, snd_q};
    end else if (accept && item_i.command == CMD_PATTERN) begin
      pat_we            = pat_ok;
      pat_waddr         = PW'(item_i.pattern_index);
      pat_wr.loop_beats = item_i.length_beats;
      pat_wr.base       = item_i.base_pitch;
      pat_wr.on         = item_i.active;
      pat_wdata         = {pat_wr, {NOTES{1'b0}}};
    end else if (accept && item_i.command == CMD_NOTE) begin
      slot_we    = note_ok;
      slot_waddr = SW'(32'(item_i.pattern_index) * NOTES + 32'(item_i.note_index));
      slot_wr.start_sixteenths  = item_i.start_sixteenths;
      slot_wr.length_sixteenths = item_i.length_sixteenths;
      slot_wr.pitch             = item_i.pitch_offset;
      slot_wdata = slot_wr;
    end
  end

  always_comb begin
    new_res                = '0;
    new_res.event_frame    = frame_q;
    new_res.status_byte    = eval.note_on ? STATUS_ON : STATUS_OFF;
    new_res.note_number    = eval.pitch;
    new_res.note_velocity  = eval.note_on ? VEL_ON : VEL_OFF;
    new_res.source_pattern = 1'(pat_q);
    new_res.source_slot    = 3'(eval_slot);
  end

  always_comb begin
    state_d    = state_q;
    clr_d      = clr_q;
    pat_d      = pat_q;
    base_d     = base_q;
    iss_d      = iss_q;
    v1_d       = 1'b0;
    n1_d       = n1_q;
    frame_d    = frame_q;
    pos_d      = pos_q;
    loop_end_d = loop_end_q;
    ploop_d    = ploop_q;
    pbase_d    = pbase_q;
    snd_d      = snd_q;
    pend_d     = pend_q;
    pend_res_d = pend_res_q;
    res_d      = res_q;
    res_vld_d  = 1'b0;

    // keep one event back so the final one of a tick can be flagged
    if (eval.note_on || eval.note_stop) begin
      snd_d[eval_slot] = eval.note_on;
      if (pend_q) begin
        res_d     = pend_res_q;
        res_vld_d = 1'b1;
      end
      pend_d     = 1'b1;
      pend_res_d = new_res;
    end

    unique case (state_q)
      ST_CLEAR: begin
        clr_d = clr_q + SW'(1);
        if (clr_q == SW'(SLOTS - 1)) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (accept && item_i.command == CMD_TICK && play_q) begin
          frame_d = item_i.frame_offset;
          pat_d   = '0;
          base_d  = '0;
          state_d = ST_PREAD;
        end
      end
      ST_PREAD: begin
        state_d = ST_PLOAD;
      end
      ST_PLOAD: begin
        if (pat_rd.on) begin
          pos_d      = pat_rd.pos;
          ploop_d    = pat_rd.loop_beats;
          pbase_d    = pat_rd.base;
          snd_d      = pat_rdata[NOTES-1:0];
          loop_end_d = LoopW'(pat_rd.loop_beats) * LoopW'(fpb_q);
          iss_d      = '0;
          state_d    = ST_WALK;
        end else if (pat_last) begin
          state_d = ST_DONE;
        end else begin
          pat_d   = pat_q + PW'(1);
          base_d  = base_q + SW'(NOTES);
          state_d = ST_PREAD;
        end
      end
      ST_WALK: begin
        if (iss_q != NCW'(NOTES)) begin
          v1_d  = 1'b1;
          n1_d  = iss_q[NW-1:0];
          iss_d = iss_q + NCW'(1);
        end else if (!v1_q && !eval.pipe_busy) begin
          state_d = ST_WBACK;
        end
      end
      ST_WBACK: begin
        if (pat_last) begin
          state_d = ST_DONE;
        end else begin
          pat_d   = pat_q + PW'(1);
          base_d  = base_q + SW'(NOTES);
          state_d = ST_PREAD;
        end
      end
      ST_DONE: begin
        if (pend_q) begin
          res_d            = pend_res_q;
          res_d.last_event = 1'b1;
          res_vld_d        = 1'b1;
          pend_d           = 1'b0;
        end
        state_d = ST_IDLE;
      end
      default: begin
        state_d = ST_CLEAR;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_CLEAR;
      clr_q     <= '0;
      pat_q     <= '0;
      base_q    <= '0;
      iss_q     <= '0;
      v1_q      <= 1'b0;
      pend_q    <= 1'b0;
      res_vld_q <= 1'b0;
      fpb_q     <= FPB_RESET;
      play_q    <= 1'b0;
    end else begin
      state_q   <= state_d;
      clr_q     <= clr_d;
      pat_q     <= pat_d;
      base_q    <= base_d;
      iss_q     <= iss_d;
      v1_q      <= v1_d;
      pend_q    <= pend_d;
      res_vld_q <= res_vld_d;
      if (cfg_we_i) begin
        unique case (cfg_addr_i)
          CFG_FPB:  fpb_q  <= cfg_wdata_i;
          CFG_PLAY: play_q <= cfg_wdata_i[0];
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    n1_q       <= n1_d;
    frame_q    <= frame_d;
    pos_q      <= pos_d;
    loop_end_q <= loop_end_d;
    ploop_q    <= ploop_d;
    pbase_q    <= pbase_d;
    snd_q      <= snd_d;
    pend_res_q <= pend_res_d;
    res_q      <= res_d;
  end

  assign result_valid_o = res_vld_q;
  assign result_o       = res_q;

endmodule

`default_nettype wire

// ===== hdl/msq_checker.sv =====
// port level checks of the sequencer and their bind
`default_nettype none

module msq_checker import msq_pkg::*; (
  input wire logic    clk_i,
  input wire logic    rst_ni,
  input wire logic    start,
  input wire logic    busy,
  input wire item_t   item_i,
  input wire logic    result_valid_o,
  input wire result_t result_o
);

  // more words of the same tick follow, so the block is still at work
  a_nonlast_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && !result_o.last_event |-> busy)
    else $error("non-final word seen while idle");

  a_last_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && result_o.last_event |-> !busy)
    else $error("final word seen while still busy");

  a_status_vel: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |->
      (result_o.status_byte == STATUS_ON && result_o.note_velocity == VEL_ON) ||
      (result_o.status_byte == STATUS_OFF && result_o.note_velocity == VEL_OFF))
    else $error("status and velocity disagree");

  a_write_one_cycle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy && item_i.command != CMD_TICK |=> !busy)
    else $error("write command left the block busy");

endmodule

bind midi_pattern_step_sequencer_unit msq_checker u_msq_checker (.*);

`default_nettype wire
